// File: hw/rtl/asa_pkg.sv
// Shared types, codes and helpers for the alignment statistics accumulator.
`default_nettype none

package asa_pkg;

    // Default histogram depths
    localparam int HIT_BINS_DEF  = 256;
    localparam int MISM_BINS_DEF = 64;

    // Entries in the front-to-back command queue
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        ACT_RECORD      = 2'd0,
        ACT_READ_HIT    = 2'd1,
        ACT_READ_MISM   = 2'd2,
        ACT_READ_TOTALS = 2'd3
    } asa_action_t;

    // Running totals, snapshotted by the front for read actions
    typedef struct packed {
        logic        [31:0] starts;
        logic signed [31:0] balance;
        logic        [15:0] length;
    } asa_totals_t;

    // Classified command handed from the front to the back
    typedef struct packed {
        asa_action_t action;
        logic        mapped;
        logic        bin_zero;
        asa_totals_t totals;
    } asa_cmd_t;

    // Saturating increment of an unsigned 32-bit counter
    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/asa_if.sv
// Valid/ready channel interfaces for alignment records and read results.
`default_nettype none

interface asa_item_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  action;
    logic               unmapped;
    logic               reverse_strand;
    logic signed [15:0] ref_id;
    logic        [30:0] position;
    logic        [15:0] hit_count;
    logic        [15:0] mismatch_count;
    logic        [15:0] read_len;
    logic        [7:0]  bin_index;

    modport source (
        output valid, action, unmapped, reverse_strand, ref_id, position,
               hit_count, mismatch_count, read_len, bin_index,
        input  ready
    );
    modport sink (
        input  valid, action, unmapped, reverse_strand, ref_id, position,
               hit_count, mismatch_count, read_len, bin_index,
        output ready
    );
endinterface

interface asa_result_if;
    logic               valid;
    logic               ready;
    logic        [31:0] bin_count;
    logic        [31:0] distinct_starts;
    logic signed [31:0] strand_balance;
    logic        [15:0] captured_length;

    modport source (
        output valid, bin_count, distinct_starts, strand_balance, captured_length,
        input  ready
    );
    modport sink (
        input  valid, bin_count, distinct_starts, strand_balance, captured_length,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/alignment_stats_accumulator.sv
// Top level of the alignment statistics accumulator.
//
//   channel  dir  handshake          payload
//   item     in   valid / ready      action, record fields, bin_index
//   result   out  valid / ready      bin_count, distinct_starts, strand_balance,
//                                    captured_length
//
// One item per cycle sustained unless clearing or a stalled result holds the
// flow; a read result passes the queue and the execute stage (registered memory
// read) and waits in the result register until it transfers out.
// Same-bin histogram updates in consecutive cycles are forwarded from the
// last write, so the read-modify-write loop never stalls.
// After reset a clearing pass steps through max(HIT_BINS, MISMATCH_BINS) bin
// addresses and zeroes both histograms; item.ready stays low meanwhile.
// A stalled result backs up into the execute stage, then the queue, and only
// then drops item.ready.
`default_nettype none

module alignment_stats_accumulator #(
    parameter int HIT_BINS      = asa_pkg::HIT_BINS_DEF,
    parameter int MISMATCH_BINS = asa_pkg::MISM_BINS_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    asa_item_if.sink     item,
    asa_result_if.source result
);
    import asa_pkg::*;

    localparam int HAW   = $clog2(HIT_BINS);
    localparam int MAW   = $clog2(MISMATCH_BINS);
    localparam int QW    = $bits(asa_cmd_t) + HAW + MAW;

    logic            push_valid;
    logic            push_ready;
    asa_cmd_t        push_cmd;
    logic [HAW-1:0]  push_hit_addr;
    logic [MAW-1:0]  push_mism_addr;
    logic            pop_valid;
    logic            pop_ready;
    logic [QW-1:0]   pop_data;
    asa_cmd_t        pop_cmd;
    logic [HAW-1:0]  pop_hit_addr;
    logic [MAW-1:0]  pop_mism_addr;
    logic            clearing;

    asa_front #(
        .HIT_BINS      (HIT_BINS),
        .MISMATCH_BINS (MISMATCH_BINS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item),
        .clearing       (clearing),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_cmd       (push_cmd),
        .push_hit_addr  (push_hit_addr),
        .push_mism_addr (push_mism_addr)
    );

    asa_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_cmd, push_hit_addr, push_mism_addr}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Split the queue entry back into command and bin addresses
    assign {pop_cmd, pop_hit_addr, pop_mism_addr} = pop_data;

    asa_back #(
        .HIT_BINS      (HIT_BINS),
        .MISMATCH_BINS (MISMATCH_BINS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_cmd       (pop_cmd),
        .pop_hit_addr  (pop_hit_addr),
        .pop_mism_addr (pop_mism_addr),
        .clearing      (clearing),
        .result        (result)
    );

endmodule

`default_nettype wire

// File: hw/rtl/asa_front.sv
// Front end: accepts records, classifies bins and keeps the scalar totals.
`default_nettype none

module asa_front #(
    parameter int HIT_BINS      = 256,
    parameter int MISMATCH_BINS = 64,
    localparam int HAW = $clog2(HIT_BINS),
    localparam int MAW = $clog2(MISMATCH_BINS)
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    asa_item_if.sink             item,
    input  wire logic            clearing,
    output logic                 push_valid,
    input  wire logic            push_ready,
    output asa_pkg::asa_cmd_t    push_cmd,
    output logic [HAW-1:0]       push_hit_addr,
    output logic [MAW-1:0]       push_mism_addr
);
    import asa_pkg::*;

    localparam logic [16:0] HIT_TOP  = 17'(HIT_BINS - 1);
    localparam logic [16:0] MISM_TOP = 17'(MISMATCH_BINS - 1);
    localparam logic [12:0] HIT_N    = 13'(HIT_BINS);
    localparam logic [12:0] MISM_N   = 13'(MISMATCH_BINS);

    logic        [31:0] starts_reg,   starts_next;
    logic signed [31:0] balance_reg,  balance_next;
    logic        [15:0] length_reg,   length_next;
    logic        [15:0] prev_ref_reg, prev_ref_next;
    logic        [31:0] prev_fwd_reg, prev_fwd_next;
    logic        [31:0] prev_rev_reg, prev_rev_next;

    asa_action_t        act;
    logic               accept;
    logic        [15:0] hits_eff;
    logic [HAW-1:0]     rec_hit_addr;
    logic [MAW-1:0]     rec_mism_addr;
    logic               idx_hit_oob;
    logic               idx_mism_oob;
    logic        [31:0] start_pos;
    logic               ref_changed;
    logic        [31:0] fwd_cur;
    logic        [31:0] rev_cur;

    assign act        = asa_action_t'(item.action);
    assign item.ready = push_ready && !clearing;
    assign push_valid = item.valid && !clearing;
    assign accept     = item.valid && item.ready;

    // Clip record bins to the top bin, map zero hits to bin 1, flag read indices out of range
    always_comb
    begin
        hits_eff = (item.hit_count == 16'd0) ? 16'd1 : item.hit_count;
        if ({1'b0, hits_eff} > HIT_TOP)
            rec_hit_addr = HIT_TOP[HAW-1:0];
        else
            rec_hit_addr = HAW'(hits_eff);
        if ({1'b0, item.mismatch_count} > MISM_TOP)
            rec_mism_addr = MISM_TOP[MAW-1:0];
        else
            rec_mism_addr = MAW'(item.mismatch_count);
        idx_hit_oob  = {5'b0, item.bin_index} >= HIT_N;
        idx_mism_oob = {5'b0, item.bin_index} >= MISM_N;
    end

    // Build the command for the back end
    always_comb
    begin
        push_cmd.action         = act;
        push_cmd.mapped         = !item.unmapped;
        push_cmd.totals.starts  = starts_reg;
        push_cmd.totals.balance = balance_reg;
        push_cmd.totals.length  = length_reg;
        unique case (act)
            ACT_RECORD:
            begin
                push_hit_addr     = item.unmapped ? '0 : rec_hit_addr;
                push_mism_addr    = rec_mism_addr;
                push_cmd.bin_zero = 1'b0;
            end
            ACT_READ_HIT:
            begin
                push_hit_addr     = HAW'(item.bin_index);
                push_mism_addr    = MAW'(item.bin_index);
                push_cmd.bin_zero = idx_hit_oob;
            end
            ACT_READ_MISM:
            begin
                push_hit_addr     = HAW'(item.bin_index);
                push_mism_addr    = MAW'(item.bin_index);
                push_cmd.bin_zero = idx_mism_oob;
            end
            ACT_READ_TOTALS:
            begin
                push_hit_addr     = HAW'(item.bin_index);
                push_mism_addr    = MAW'(item.bin_index);
                push_cmd.bin_zero = 1'b1;
            end
        endcase
    end

    // Update captured length on each record, and starts and balance on each mapped record
    always_comb
    begin
        start_pos     = {1'b0, item.position} + 32'd1;
        ref_changed   = item.ref_id != prev_ref_reg;
        fwd_cur       = ref_changed ? 32'd0 : prev_fwd_reg;
        rev_cur       = ref_changed ? 32'd0 : prev_rev_reg;
        starts_next   = starts_reg;
        balance_next  = balance_reg;
        length_next   = length_reg;
        prev_ref_next = prev_ref_reg;
        prev_fwd_next = prev_fwd_reg;
        prev_rev_next = prev_rev_reg;
        if (accept && act == ACT_RECORD)
        begin
            if (length_reg == 16'd0)
                length_next = item.read_len;
            if (!item.unmapped)
            begin
                prev_ref_next = item.ref_id;
                prev_fwd_next = fwd_cur;
                prev_rev_next = rev_cur;
                if (item.reverse_strand)
                begin
                    if (start_pos > rev_cur)
                        starts_next = sat_inc(starts_reg);
                    prev_rev_next = start_pos;
                    if (balance_reg != 32'sh8000_0000)
                        balance_next = balance_reg - 32'sd1;
                end
                else
                begin
                    if (start_pos > fwd_cur)
                        starts_next = sat_inc(starts_reg);
                    prev_fwd_next = start_pos;
                    if (balance_reg != 32'sh7FFF_FFFF)
                        balance_next = balance_reg + 32'sd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            starts_reg   <= '0;
            balance_reg  <= '0;
            length_reg   <= '0;
            prev_ref_reg <= 16'hFFFF;
            prev_fwd_reg <= '0;
            prev_rev_reg <= '0;
        end
        else
        begin
            starts_reg   <= starts_next;
            balance_reg  <= balance_next;
            length_reg   <= length_next;
            prev_ref_reg <= prev_ref_next;
            prev_fwd_reg <= prev_fwd_next;
            prev_rev_reg <= prev_rev_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/asa_queue.sv
// Small FIFO that decouples the front end from the back end.
`default_nettype none

module asa_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic      [WIDTH-1:0] pop_data
);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg,  count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != FULL;
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// File: hw/rtl/asa_back.sv
// Back end: histogram memories, read-modify-write with forwarding, results.
`default_nettype none

module asa_back #(
    parameter int HIT_BINS      = 256,
    parameter int MISMATCH_BINS = 64,
    localparam int HAW = $clog2(HIT_BINS),
    localparam int MAW = $clog2(MISMATCH_BINS)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               pop_valid,
    output logic                    pop_ready,
    input  wire asa_pkg::asa_cmd_t  pop_cmd,
    input  wire logic [HAW-1:0]     pop_hit_addr,
    input  wire logic [MAW-1:0]     pop_mism_addr,
    output logic                    clearing,
    asa_result_if.source            result
);
    import asa_pkg::*;

    localparam int CLR_N = (HIT_BINS > MISMATCH_BINS) ? HIT_BINS : MISMATCH_BINS;
    localparam int CW    = $clog2(CLR_N);
    localparam logic [CW-1:0] CLR_LAST = CW'(CLR_N - 1);
    localparam logic [CW:0]   HIT_N    = (CW + 1)'(HIT_BINS);
    localparam logic [CW:0]   MISM_N   = (CW + 1)'(MISMATCH_BINS);

    logic [31:0] hit_mem  [HIT_BINS];
    logic [31:0] mism_mem [MISMATCH_BINS];

    // Clearing pass
    logic            clearing_reg, clearing_next;
    logic [CW-1:0]   clr_cnt_reg,  clr_cnt_next;

    // Execute stage
    logic            b_valid_reg,  b_valid_next;
    asa_cmd_t        b_cmd_reg;
    logic [HAW-1:0]  b_hit_addr_reg;
    logic [MAW-1:0]  b_mism_addr_reg;
    logic [31:0]     hit_rd_reg;
    logic [31:0]     mism_rd_reg;

    // Last write of each histogram, for back-to-back same-bin updates
    logic            hlw_valid_reg, hlw_valid_next;
    logic [HAW-1:0]  hlw_addr_reg;
    logic [31:0]     hlw_data_reg;
    logic            mlw_valid_reg, mlw_valid_next;
    logic [MAW-1:0]  mlw_addr_reg;
    logic [31:0]     mlw_data_reg;

    // Result register
    logic            out_valid_reg, out_valid_next;
    logic [31:0]     out_bin_reg;
    asa_totals_t     out_tot_reg;

    logic            b_rec;
    logic            out_free;
    logic            adv;
    logic            load;
    logic            out_load;
    logic [31:0]     hit_cur;
    logic [31:0]     mism_cur;
    logic [31:0]     bin_val;
    logic            hit_we_b;
    logic            mism_we_b;
    logic            hit_we;
    logic            mism_we;
    logic [HAW-1:0]  hit_wa;
    logic [MAW-1:0]  mism_wa;
    logic [31:0]     hit_wd;
    logic [31:0]     mism_wd;

    assign clearing  = clearing_reg;
    assign b_rec     = b_valid_reg && (b_cmd_reg.action == ACT_RECORD);
    assign out_free  = !out_valid_reg || result.ready;
    assign adv       = !b_valid_reg || b_rec || out_free;
    assign pop_ready = adv && !clearing_reg;
    assign load      = pop_valid && pop_ready;
    assign out_load  = b_valid_reg && !b_rec && out_free;

    // Forward the latest write over stale read data
    assign hit_cur  = (hlw_valid_reg && hlw_addr_reg == b_hit_addr_reg) ?
                      hlw_data_reg : hit_rd_reg;
    assign mism_cur = (mlw_valid_reg && mlw_addr_reg == b_mism_addr_reg) ?
                      mlw_data_reg : mism_rd_reg;

    assign hit_we_b  = b_rec;
    assign mism_we_b = b_rec && b_cmd_reg.mapped;

    // Select memory writes: clearing pass or bin update
    always_comb
    begin
        if (clearing_reg)
        begin
            hit_we  = {1'b0, clr_cnt_reg} < HIT_N;
            mism_we = {1'b0, clr_cnt_reg} < MISM_N;
            hit_wa  = HAW'(clr_cnt_reg);
            mism_wa = MAW'(clr_cnt_reg);
            hit_wd  = '0;
            mism_wd = '0;
        end
        else
        begin
            hit_we  = hit_we_b;
            mism_we = mism_we_b;
            hit_wa  = b_hit_addr_reg;
            mism_wa = b_mism_addr_reg;
            hit_wd  = sat_inc(hit_cur);
            mism_wd = sat_inc(mism_cur);
        end
    end

    // Pick the bin value of a read action
    always_comb
    begin
        bin_val = '0;
        if (!b_cmd_reg.bin_zero)
        begin
            unique case (b_cmd_reg.action)
                ACT_READ_HIT:    bin_val = hit_cur;
                ACT_READ_MISM:   bin_val = mism_cur;
                ACT_RECORD:      bin_val = '0;
                ACT_READ_TOTALS: bin_val = '0;
            endcase
        end
    end

    // Next values of control state
    always_comb
    begin
        clearing_next  = clearing_reg;
        clr_cnt_next   = clr_cnt_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + CW'(1);
            if (clr_cnt_reg == CLR_LAST)
                clearing_next = 1'b0;
        end
        b_valid_next   = adv ? load : b_valid_reg;
        hlw_valid_next = clearing_reg ? 1'b0 : (hlw_valid_reg || hit_we_b);
        mlw_valid_next = clearing_reg ? 1'b0 : (mlw_valid_reg || mism_we_b);
        if (out_load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            b_valid_reg   <= 1'b0;
            hlw_valid_reg <= 1'b0;
            mlw_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clr_cnt_reg   <= clr_cnt_next;
            b_valid_reg   <= b_valid_next;
            hlw_valid_reg <= hlw_valid_next;
            mlw_valid_reg <= mlw_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload of the execute stage, last writes and result
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            b_cmd_reg       <= pop_cmd;
            b_hit_addr_reg  <= pop_hit_addr;
            b_mism_addr_reg <= pop_mism_addr;
        end
        if (hit_we_b && !clearing_reg)
        begin
            hlw_addr_reg <= b_hit_addr_reg;
            hlw_data_reg <= hit_wd;
        end
        if (mism_we_b && !clearing_reg)
        begin
            mlw_addr_reg <= b_mism_addr_reg;
            mlw_data_reg <= mism_wd;
        end
        if (out_load)
        begin
            out_bin_reg <= bin_val;
            out_tot_reg <= b_cmd_reg.totals;
        end
    end

    // Hit histogram memory
    always_ff @(posedge clk)
    begin
        if (hit_we)
            hit_mem[hit_wa] <= hit_wd;
        if (load)
            hit_rd_reg <= hit_mem[pop_hit_addr];
    end

    // Mismatch histogram memory
    always_ff @(posedge clk)
    begin
        if (mism_we)
            mism_mem[mism_wa] <= mism_wd;
        if (load)
            mism_rd_reg <= mism_mem[pop_mism_addr];
    end

    assign result.valid           = out_valid_reg;
    assign result.bin_count       = out_bin_reg;
    assign result.distinct_starts = out_tot_reg.starts;
    assign result.strand_balance  = out_tot_reg.balance;
    assign result.captured_length = out_tot_reg.length;

endmodule

`default_nettype wire

// File: sim/alignment_stats_accumulator_tb.sv
// Self-checking testbench for the alignment statistics accumulator.
`default_nettype none

module alignment_stats_accumulator_tb;
    import asa_pkg::*;

    localparam int HIT_BINS      = HIT_BINS_DEF;
    localparam int MISMATCH_BINS = MISM_BINS_DEF;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int TAIL_CYCLES   = 8;
    localparam longint SAT_U32   = 64'hFFFF_FFFF;

    // One alignment record or read request as it crosses the item channel
    typedef struct {
        asa_action_t        action;
        logic               unmapped;
        logic               reverse_strand;
        logic signed [15:0] ref_id;
        logic        [30:0] position;
        logic        [15:0] hit_count;
        logic        [15:0] mismatch_count;
        logic        [15:0] read_len;
        logic        [7:0]  bin_index;
    } align_item_t;

    typedef struct {
        logic        [31:0] bin_count;
        logic        [31:0] distinct_starts;
        logic signed [31:0] strand_balance;
        logic        [15:0] captured_length;
    } stats_reply_t;

    // Stimulus row; a fixed reply, when given, replaces the predicted one
    typedef struct {
        align_item_t  it;
        bit           fixed;
        stats_reply_t want;
    } stim_row_t;

    typedef enum int {
        FLOW,
        LIGHT_STALL,
        HEAVY_STALL,
        HOLD
    } stall_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    asa_item_if   item_if ();
    asa_result_if result_if ();

    alignment_stats_accumulator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Statistics state mirrored from the block
    logic        [31:0] hit_hist  [HIT_BINS]      = '{default: '0};
    logic        [31:0] mism_hist [MISMATCH_BINS] = '{default: '0};
    logic        [31:0] start_total = '0;
    logic signed [31:0] fwd_minus_rev = '0;
    logic        [15:0] first_length = '0;
    logic        [15:0] last_ref = 16'hFFFF;
    logic        [31:0] last_fwd_start = '0;
    logic        [31:0] last_rev_start = '0;

    stats_reply_t pending_replies [$];
    stim_row_t    row_overrides [$];
    stim_row_t    directed_rows [$];
    bit           mismatch_seen = 1'b0;

    // Stimulus generator state
    int          burst_left = 0;
    logic [15:0] walk_ref = '0;
    logic [30:0] walk_pos = '0;

    // Receiver stall pattern state
    stall_mode_t stall_mode = FLOW;
    int          stall_left = 0;

    function automatic logic [31:0] bump_sat(input logic [31:0] count);
        return (count == SAT_U32[31:0]) ? count : count + 32'd1;
    endfunction

    // Apply one accepted item to the statistics; reads produce a reply
    task automatic update_stats(input align_item_t it, output bit replies,
                                output stats_reply_t rep);
        int          hbin;
        int          mbin;
        logic [31:0] start_plus1;
        replies = 1'b0;
        rep = '{default: '0};
        if (it.action == ACT_RECORD)
        begin
            if (first_length == 16'd0)
                first_length = it.read_len;
            if (it.unmapped)
            begin
                hit_hist[0] = bump_sat(hit_hist[0]);
            end
            else
            begin
                hbin = (it.hit_count == 16'd0) ? 1 : int'(it.hit_count);
                if (hbin >= HIT_BINS)
                    hbin = HIT_BINS - 1;
                hit_hist[hbin] = bump_sat(hit_hist[hbin]);
                mbin = int'(it.mismatch_count);
                if (mbin >= MISMATCH_BINS)
                    mbin = MISMATCH_BINS - 1;
                mism_hist[mbin] = bump_sat(mism_hist[mbin]);
                // New reference forgets the last start on both strands
                if (it.ref_id != last_ref)
                begin
                    last_ref = it.ref_id;
                    last_fwd_start = '0;
                    last_rev_start = '0;
                end
                start_plus1 = {1'b0, it.position} + 32'd1;
                if (it.reverse_strand)
                begin
                    if (start_plus1 > last_rev_start)
                        start_total = bump_sat(start_total);
                    last_rev_start = start_plus1;
                    if (fwd_minus_rev != 32'sh8000_0000)
                        fwd_minus_rev = fwd_minus_rev - 32'sd1;
                end
                else
                begin
                    if (start_plus1 > last_fwd_start)
                        start_total = bump_sat(start_total);
                    last_fwd_start = start_plus1;
                    if (fwd_minus_rev != 32'sh7FFF_FFFF)
                        fwd_minus_rev = fwd_minus_rev + 32'sd1;
                end
            end
        end
        else
        begin
            replies = 1'b1;
            if (it.action == ACT_READ_HIT && int'(it.bin_index) < HIT_BINS)
                rep.bin_count = hit_hist[it.bin_index];
            else if (it.action == ACT_READ_MISM && int'(it.bin_index) < MISMATCH_BINS)
                rep.bin_count = mism_hist[it.bin_index];
            rep.distinct_starts = start_total;
            rep.strand_balance  = fwd_minus_rev;
            rep.captured_length = first_length;
        end
    endtask

    function automatic align_item_t record_of(input bit unm, input bit rev, input int ref_no,
                                              input int pos, input int hits, input int mism,
                                              input int rlen);
        align_item_t it;
        it = '{action: ACT_RECORD, default: '0};
        it.action         = ACT_RECORD;
        it.unmapped       = unm;
        it.reverse_strand = rev;
        it.ref_id         = 16'(ref_no);
        it.position       = 31'(pos);
        it.hit_count      = 16'(hits);
        it.mismatch_count = 16'(mism);
        it.read_len       = 16'(rlen);
        return it;
    endfunction

    function automatic align_item_t query_of(input asa_action_t act, input int idx);
        align_item_t it;
        it = '{action: ACT_RECORD, default: '0};
        it.action    = act;
        it.bin_index = 8'(idx);
        return it;
    endfunction

    function automatic stats_reply_t reply_of(input longint bin, input longint starts,
                                              input int bal, input int len);
        stats_reply_t rep;
        rep.bin_count       = 32'(bin);
        rep.distinct_starts = 32'(starts);
        rep.strand_balance  = 32'(bal);
        rep.captured_length = 16'(len);
        return rep;
    endfunction

    task automatic add_row(input align_item_t it, input bit fixed, input stats_reply_t want);
        stim_row_t row;
        row.it    = it;
        row.fixed = fixed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // Mostly well-formed sorted alignments; some reads and some noise
    function automatic align_item_t next_random_item();
        align_item_t it;
        int          pick;
        int          sel;
        pick = $urandom_range(0, 99);
        it.action         = ACT_RECORD;
        it.unmapped       = ($urandom_range(0, 7) == 0);
        it.reverse_strand = 1'($urandom_range(0, 1));
        it.ref_id         = 16'(int'($urandom_range(32768, 0)) - 1);
        it.position       = 31'($urandom_range(2147483646, 0));
        it.hit_count      = 16'($urandom);
        it.mismatch_count = 16'($urandom);
        it.read_len       = 16'($urandom);
        it.bin_index      = 8'($urandom);
        if (pick < 8)
        begin
            it.action = asa_action_t'($urandom_range(0, 3));
        end
        else if (pick < 35)
        begin
            it.action = asa_action_t'($urandom_range(1, 3));
            if ($urandom_range(0, 9) < 7)
                it.bin_index = 8'($urandom_range(0, 70));
        end
        else
        begin
            // Walk the reference and position like a coordinate-sorted file
            sel = $urandom_range(0, 99);
            if (sel < 3)
                walk_ref = 16'(int'($urandom_range(41, 0)) - 1);
            else if (sel < 4)
                walk_ref = it.ref_id;
            it.ref_id = walk_ref;
            sel = $urandom_range(0, 9);
            if (sel == 0)
                walk_pos = it.position;
            else if (sel == 1)
                walk_pos = walk_pos - 31'($urandom_range(0, 20));
            else
                walk_pos = walk_pos + 31'($urandom_range(0, 40));
            if (walk_pos > 31'd2147483600)
                walk_pos = '0;
            it.position = walk_pos;
            sel = $urandom_range(0, 19);
            if (sel < 12)
                it.hit_count = 16'($urandom_range(0, 4));
            else if (sel < 17)
                it.hit_count = 16'($urandom_range(0, 300));
            sel = $urandom_range(0, 19);
            if (sel < 12)
                it.mismatch_count = 16'($urandom_range(0, 8));
            else if (sel < 17)
                it.mismatch_count = 16'($urandom_range(0, 80));
        end
        return it;
    endfunction

    // Offer one item in bursts with random gaps; return once it transfers
    task automatic offer_item(input stim_row_t row);
        int gap;
        row_overrides.push_back(row);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                item_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_if.valid          <= 1'b1;
        item_if.action         <= row.it.action;
        item_if.unmapped       <= row.it.unmapped;
        item_if.reverse_strand <= row.it.reverse_strand;
        item_if.ref_id         <= row.it.ref_id;
        item_if.position       <= row.it.position;
        item_if.hit_count      <= row.it.hit_count;
        item_if.mismatch_count <= row.it.mismatch_count;
        item_if.read_len       <= row.it.read_len;
        item_if.bin_index      <= row.it.bin_index;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
    endtask

    // Predict on every item transfer
    always @(posedge clk)
    begin : track_items
        align_item_t  seen;
        stim_row_t    row;
        bit           replies;
        stats_reply_t rep;
        if (rst_n && item_if.valid && item_if.ready)
        begin
            seen.action         = asa_action_t'(item_if.action);
            seen.unmapped       = item_if.unmapped;
            seen.reverse_strand = item_if.reverse_strand;
            seen.ref_id         = item_if.ref_id;
            seen.position       = item_if.position;
            seen.hit_count      = item_if.hit_count;
            seen.mismatch_count = item_if.mismatch_count;
            seen.read_len       = item_if.read_len;
            seen.bin_index      = item_if.bin_index;
            row = row_overrides.pop_front();
            update_stats(seen, replies, rep);
            if (replies)
                pending_replies.push_back(row.fixed ? row.want : rep);
        end
    end

    // Compare each result transfer against the oldest pending reply
    always @(posedge clk)
    begin : check_results
        stats_reply_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("result transfer with no reply pending");
                mismatch_seen = 1'b1;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (result_if.bin_count !== want.bin_count)
                begin
                    $error("bin_count: expected %0d, got %0d",
                           want.bin_count, result_if.bin_count);
                    mismatch_seen = 1'b1;
                end
                if (result_if.distinct_starts !== want.distinct_starts)
                begin
                    $error("distinct_starts: expected %0d, got %0d",
                           want.distinct_starts, result_if.distinct_starts);
                    mismatch_seen = 1'b1;
                end
                if (result_if.strand_balance !== want.strand_balance)
                begin
                    $error("strand_balance: expected %0d, got %0d",
                           want.strand_balance, result_if.strand_balance);
                    mismatch_seen = 1'b1;
                end
                if (result_if.captured_length !== want.captured_length)
                begin
                    $error("captured_length: expected %0d, got %0d",
                           want.captured_length, result_if.captured_length);
                    mismatch_seen = 1'b1;
                end
            end
        end
    end

    // Receiver back-pressure: phases of free flow, light, heavy and full stall
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = (stall_mode == HOLD) ? $urandom_range(1, 40) : $urandom_range(16, 160);
        end
        stall_left--;
        case (stall_mode)
            FLOW:        result_if.ready <= 1'b1;
            LIGHT_STALL: result_if.ready <= ($urandom_range(0, 3) != 0);
            HEAVY_STALL: result_if.ready <= ($urandom_range(0, 3) == 0);
            default:     result_if.ready <= 1'b0;
        endcase
    end

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t    row;
        stats_reply_t none;
        int           drain;
        none = '{default: '0};
        item_if.valid          <= 1'b0;
        item_if.action         <= ACT_RECORD;
        item_if.unmapped       <= 1'b0;
        item_if.reverse_strand <= 1'b0;
        item_if.ref_id         <= '0;
        item_if.position       <= '0;
        item_if.hit_count      <= '0;
        item_if.mismatch_count <= '0;
        item_if.read_len       <= '0;
        item_if.bin_index      <= '0;

        // Reads straight after reset see cleared state
        add_row(query_of(ACT_READ_TOTALS, 0), 1'b1, reply_of(0, 0, 0, 0));
        add_row(query_of(ACT_READ_HIT, 0), 1'b1, reply_of(0, 0, 0, 0));
        add_row(query_of(ACT_READ_MISM, 63), 1'b1, reply_of(0, 0, 0, 0));
        add_row(query_of(ACT_READ_MISM, 255), 1'b1, reply_of(0, 0, 0, 0));
        // Unmapped record only bumps hit bin 0; zero length is not captured
        add_row(record_of(1, 1, 5, 100, 7, 7, 0), 1'b0, none);
        add_row(query_of(ACT_READ_HIT, 0), 1'b1, reply_of(1, 0, 0, 0));
        // Zero hit count lands in bin 1; first nonzero length is captured
        add_row(record_of(0, 0, -1, 0, 0, 0, 65535), 1'b0, none);
        // Field extremes: top bins via clamping, reference change
        add_row(record_of(0, 1, 32767, 2147483646, 65535, 65535, 1), 1'b0, none);
        // Repeated and backward starts on the reverse strand, same bins back to back
        add_row(record_of(0, 1, 32767, 2147483646, 2, 1, 0), 1'b0, none);
        add_row(record_of(0, 1, 32767, 10, 2, 1, 0), 1'b0, none);
        add_row(record_of(0, 1, 32767, 10, 2, 1, 0), 1'b0, none);
        // Just past the top bins of both histograms
        add_row(record_of(0, 0, 32767, 3, 256, 64, 0), 1'b0, none);
        add_row(query_of(ACT_READ_TOTALS, 255), 1'b1, reply_of(0, 3, -2, 65535));
        add_row(query_of(ACT_READ_HIT, 255), 1'b1, reply_of(2, 3, -2, 65535));
        add_row(query_of(ACT_READ_HIT, 2), 1'b1, reply_of(3, 3, -2, 65535));
        add_row(query_of(ACT_READ_MISM, 63), 1'b1, reply_of(2, 3, -2, 65535));
        add_row(query_of(ACT_READ_MISM, 64), 1'b1, reply_of(0, 3, -2, 65535));
        add_row(record_of(0, 0, 0, 3, 1, 0, 0), 1'b0, none);
        add_row(query_of(ACT_READ_HIT, 1), 1'b0, none);
        add_row(query_of(ACT_READ_MISM, 0), 1'b1, reply_of(2, 4, -1, 65535));
        add_row(record_of(1, 0, -1, 0, 0, 0, 0), 1'b0, none);
        add_row(query_of(ACT_READ_HIT, 0), 1'b1, reply_of(2, 4, -1, 65535));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer_item(directed_rows[i]);

        row.fixed = 1'b0;
        row.want  = none;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            row.it = next_random_item();
            offer_item(row);
        end
        item_if.valid <= 1'b0;

        // Drain outstanding replies, then let the pipeline settle
        @(posedge clk);
        drain = 0;
        while (pending_replies.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        if (pending_replies.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_replies.size());
            mismatch_seen = 1'b1;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (!mismatch_seen)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
hw/rtl/asa_pkg.sv
hw/rtl/asa_if.sv
hw/rtl/asa_front.sv
hw/rtl/asa_queue.sv
hw/rtl/asa_back.sv
hw/rtl/alignment_stats_accumulator.sv
sim/alignment_stats_accumulator_tb.sv
